[rtl/core/tfc_pkg.sv]
// Shared types, constants and mixing functions of the counter-based generator.
`timescale 1ns / 1ps
package tfc_pkg;

  localparam int WORD_W           = 32;
  localparam int LANES            = 4;
  localparam int SCHED_N          = LANES + 1;
  localparam int NUM_ROUNDS       = 20;
  localparam int ROUNDS_PER_GROUP = 4;
  localparam int CFG_IDX_W        = 8;
  localparam int ROT_W            = 5;

  typedef logic [WORD_W-1:0]    word_t;
  typedef word_t [LANES-1:0]    blk_t;
  typedef word_t [SCHED_N-1:0]  sched_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  typedef logic [ROT_W-1:0]     rot_t;
  typedef rot_t [3:0]           rot_set_t;

  typedef enum cfg_idx_t {
    REG_KEY0 = 8'd0,
    REG_KEY1 = 8'd1,
    REG_KEY2 = 8'd2,
    REG_KEY3 = 8'd3
  } cfg_reg_t;

  localparam word_t PARITY_CONST = 32'h1BD1_1BDA;

  // entry 0 is the first rotation of the round
  localparam rot_set_t ROT_A = {5'd6, 5'd26, 5'd15, 5'd13};
  localparam rot_set_t ROT_B = {5'd24, 5'd16, 5'd29, 5'd17};

  function automatic word_t rol32(word_t v, rot_t s);
    logic [ROT_W:0] rs;
    rs = (ROT_W+1)'(WORD_W) - {1'b0, s};
    return (v << s) | (v >> rs);
  endfunction

  // two add/rotate/xor steps, each followed by a swap of lanes 1 and 3
  function automatic blk_t mix_round(blk_t w, rot_set_t r);
    blk_t  x;
    word_t t;
    x    = w;
    x[0] = x[0] + x[1];
    x[1] = rol32(x[1], r[0]) ^ x[0];
    x[2] = x[2] + x[3];
    x[3] = rol32(x[3], r[1]) ^ x[2];
    t    = x[1];
    x[1] = x[3];
    x[3] = t;
    x[0] = x[0] + x[1];
    x[1] = rol32(x[1], r[2]) ^ x[0];
    x[2] = x[2] + x[3];
    x[3] = rol32(x[3], r[3]) ^ x[2];
    t    = x[1];
    x[1] = x[3];
    x[3] = t;
    return x;
  endfunction

endpackage

[rtl/core/tfc_in_if.sv]
// Counter block channel: valid/ready plus four counter words.
`timescale 1ns / 1ps
interface tfc_in_if;
  logic          valid;
  logic          ready;
  tfc_pkg::word_t counter_word_0;
  tfc_pkg::word_t counter_word_1;
  tfc_pkg::word_t counter_word_2;
  tfc_pkg::word_t counter_word_3;

  modport source (output valid, counter_word_0, counter_word_1, counter_word_2,
                  counter_word_3, input ready);
  modport sink   (input valid, counter_word_0, counter_word_1, counter_word_2,
                  counter_word_3, output ready);
endinterface

[rtl/core/tfc_out_if.sv]
// Random block channel: valid/ready plus four random words.
`timescale 1ns / 1ps
interface tfc_out_if;
  logic          valid;
  logic          ready;
  tfc_pkg::word_t random_word_0;
  tfc_pkg::word_t random_word_1;
  tfc_pkg::word_t random_word_2;
  tfc_pkg::word_t random_word_3;

  modport source (output valid, random_word_0, random_word_1, random_word_2,
                  random_word_3, input ready);
  modport sink   (input valid, random_word_0, random_word_1, random_word_2,
                  random_word_3, output ready);
endinterface

[rtl/core/tfc_cfg_if.sv]
// Configuration write channel: valid/ready, register index and write data.
`timescale 1ns / 1ps
interface tfc_cfg_if;
  logic              valid;
  logic              ready;
  tfc_pkg::cfg_idx_t index;
  tfc_pkg::word_t    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[rtl/core/tfc_whiten.sv]
// Entry stage: adds the first four key schedule words to the counter block.
`timescale 1ns / 1ps
module tfc_whiten (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            valid_i,
  output logic            ready_o,
  input  tfc_pkg::blk_t   blk_i,
  input  tfc_pkg::sched_t sched_i,
  output logic            valid_o,
  input  logic            ready_i,
  output tfc_pkg::blk_t   blk_o
);
  import tfc_pkg::*;

  logic valid_r;
  blk_t blk_r;
  blk_t blk_nxt;

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      blk_nxt[i] = blk_i[i] + sched_i[i];
    end
  end

  assign ready_o = !valid_r || ready_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_o) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && valid_i) begin
      blk_r <= blk_nxt;
    end
  end

  assign valid_o = valid_r;
  assign blk_o   = blk_r;

endmodule

[rtl/core/tfc_round.sv]
// One double mix round as a pipeline stage, with key injection at group ends.
`timescale 1ns / 1ps
module tfc_round #(
  parameter int ROUND = 0
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            valid_i,
  output logic            ready_o,
  input  tfc_pkg::blk_t   blk_i,
  input  tfc_pkg::sched_t sched_i,
  output logic            valid_o,
  input  logic            ready_i,
  output tfc_pkg::blk_t   blk_o
);
  import tfc_pkg::*;

  localparam bit USE_SET_B = (ROUND % 2) == 1;
  localparam bit INJECT    = (ROUND % ROUNDS_PER_GROUP) == (ROUNDS_PER_GROUP - 1);
  localparam int GROUP     = ROUND / ROUNDS_PER_GROUP + 1;

  logic valid_r;
  blk_t blk_r;
  blk_t mixed;
  blk_t blk_nxt;

  assign mixed = mix_round(blk_i, USE_SET_B ? ROT_B : ROT_A);

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    localparam int KIDX = (GROUP + i) % SCHED_N;
    if (!INJECT) begin : g_pass
      assign blk_nxt[i] = mixed[i];
    end else if (i == LANES - 1) begin : g_last
      assign blk_nxt[i] = mixed[i] + sched_i[KIDX] + WORD_W'(GROUP);
    end else begin : g_key
      assign blk_nxt[i] = mixed[i] + sched_i[KIDX];
    end
  end

  assign ready_o = !valid_r || ready_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_o) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && valid_i) begin
      blk_r <= blk_nxt;
    end
  end

  assign valid_o = valid_r;
  assign blk_o   = blk_r;

endmodule

[rtl/core/threefry_counter_prng_top.sv]
// Path: an input transfer reaches out_ch through the entry stage and 20 round stages.
// Throughput: one 128-bit block per cycle while out_ch is ready; one register stage per double mix round.
// Back-pressure: each stage takes new data when empty or when its successor takes its data.
// Reset (synchronous, rst_n low): all stage valid bits and the four key words clear to zero.
// Configuration writes are always taken; writes beyond key word 3 are ignored.
// Top level: key registers, schedule extension and the round pipeline.
`timescale 1ns / 1ps
module threefry_counter_prng_top (
  input logic      clk,
  input logic      rst_n,
  tfc_in_if.sink   in_ch,
  tfc_out_if.source out_ch,
  tfc_cfg_if.sink  cfg_ch
);
  import tfc_pkg::*;

  localparam int STAGES = NUM_ROUNDS + 1;

  word_t  key_r [LANES];
  sched_t sched;

  logic [STAGES-1:0] stage_vld;
  logic [STAGES-1:0] stage_acc;
  logic [STAGES-1:0] stage_rdy;
  blk_t              stage_blk [STAGES];
  blk_t              in_blk;

  logic in_fire;
  logic out_fire;
  logic cfg_fire;

  assign cfg_ch.ready = 1'b1;
  assign cfg_fire     = cfg_ch.valid && cfg_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LANES; i++) begin
        key_r[i] <= '0;
      end
    end else if (cfg_fire) begin
      unique case (cfg_ch.index)
        REG_KEY0: key_r[0] <= cfg_ch.data;
        REG_KEY1: key_r[1] <= cfg_ch.data;
        REG_KEY2: key_r[2] <= cfg_ch.data;
        REG_KEY3: key_r[3] <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      sched[i] = key_r[i];
    end
    sched[LANES] = key_r[0] ^ key_r[1] ^ key_r[2] ^ key_r[3] ^ PARITY_CONST;
  end

  assign in_blk[0] = in_ch.counter_word_0;
  assign in_blk[1] = in_ch.counter_word_1;
  assign in_blk[2] = in_ch.counter_word_2;
  assign in_blk[3] = in_ch.counter_word_3;

  assign stage_rdy = {out_ch.ready, stage_acc[STAGES-1:1]};

  tfc_whiten u_whiten (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (in_ch.valid),
    .ready_o (stage_acc[0]),
    .blk_i   (in_blk),
    .sched_i (sched),
    .valid_o (stage_vld[0]),
    .ready_i (stage_rdy[0]),
    .blk_o   (stage_blk[0])
  );

  for (genvar r = 0; r < NUM_ROUNDS; r++) begin : g_round
    tfc_round #(
      .ROUND (r)
    ) u_round (
      .clk     (clk),
      .rst_n   (rst_n),
      .valid_i (stage_vld[r]),
      .ready_o (stage_acc[r+1]),
      .blk_i   (stage_blk[r]),
      .sched_i (sched),
      .valid_o (stage_vld[r+1]),
      .ready_i (stage_rdy[r+1]),
      .blk_o   (stage_blk[r+1])
    );
  end

  assign in_ch.ready          = stage_acc[0];
  assign out_ch.valid         = stage_vld[STAGES-1];
  assign out_ch.random_word_0 = stage_blk[STAGES-1][0];
  assign out_ch.random_word_1 = stage_blk[STAGES-1][1];
  assign out_ch.random_word_2 = stage_blk[STAGES-1][2];
  assign out_ch.random_word_3 = stage_blk[STAGES-1][3];

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_fire = out_ch.valid && out_ch.ready;

  // input is blocked only when every stage is full and the output is stalled
  a_in_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready == (!(&stage_vld) || out_ch.ready))
    else $error("input ready does not match pipeline occupancy");

  // items in flight change only by transfers
  a_occupancy: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |->
      ($countones(stage_vld) ==
       $past($countones(stage_vld)) + int'($past(in_fire)) - int'($past(out_fire))))
    else $error("pipeline lost or duplicated an item");

  a_key0_write: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_fire && cfg_ch.index == REG_KEY0) |=> key_r[0] == $past(cfg_ch.data))
    else $error("key word 0 write not taken");

  a_key3_write: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_fire && cfg_ch.index == REG_KEY3) |=> key_r[3] == $past(cfg_ch.data))
    else $error("key word 3 write not taken");

endmodule
